>>> hdl/qwt_pkg.sv
package qwt_pkg;

    localparam int AXES       = 6;
    localparam int AXIS_BITS  = 16;
    localparam int MAX_SEGS   = 16;
    localparam int SEG_BITS   = 4;
    localparam int CNT_BITS   = 5;
    localparam int QF         = 20;             // fraction bits of progress
    localparam int GOAL_DEPTH = AXES * MAX_SEGS;
    localparam int GADDR_BITS = 7;
    localparam int DUR_BITS   = 21;
    localparam int NUM_BITS   = 41;             // widest dividend: elapsed << QF
    localparam int DEN_BITS   = 23;
    localparam int MUL_BITS   = 26;
    localparam int IN_DATA_BITS  = 152;
    localparam int OUT_DATA_BITS = 104;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CNT_BITS-1:0] SEG_COUNT_RESET = 5'd1;
    localparam logic [10:0] DUR_SCALE = 11'd2000;
    localparam logic [31:0] END_MARGIN = 32'd5;

    typedef logic signed [AXIS_BITS-1:0] t_axis;
    typedef logic signed [AXIS_BITS:0]   t_delta;

endpackage

>>> hdl/quintic_waypoint_trajectory.sv
// Minimum-jerk waypoint trajectory generator. Load beats (tuser = 0) write
// one waypoint slot (six Q10.6 axis goals and a speed) and produce no output.
// Tick beats (tuser = 1) carry the millisecond time and each produce one pose
// beat. On the first tick of a segment the start pose, deltas, duration and
// start time are latched; the pose is start + delta * (10s^3 - 15s^4 + 6s^5).
// tlast on the output marks the tick on which the last segment ended.
// One shared 26x26 multiplier and one radix-2 restoring divider do
// all the math under a sequencer, and the input is not ready while it runs.
// A load does one goal-memory write per axis. A tick runs the 41-step
// progress division unless the duration is zero; the first tick of a
// segment adds six 28-step duration divisions. A finished pose sits in
// an output register, so the next beat is accepted while it waits; a
// tick only stalls if the previous pose is still held.
module quintic_waypoint_trajectory
    import qwt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CNT_BITS-1:0]      i_cfg_wdata,     // segment_count
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // slot[3:0] roll[19:4] pitch[35:20] yaw[51:36] x[67:52] y[83:68]
    // z[99:84] speed[115:100] now_ms[147:116], zero pad above
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    input  logic                     i_s_tuser,       // operation
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // roll[15:0] pitch[31:16] yaw[47:32] x[63:48] y[79:64] z[95:80]
    // segment_now[99:96], zero pad above
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    output logic                     o_m_tlast        // sequence_done
);

    localparam logic [4:0] ST_IDLE  = 5'd0,  ST_LOAD  = 5'd1,  ST_TICK  = 5'd2,
                           ST_LRDG  = 5'd3,  ST_LRDP  = 5'd4,  ST_LDLT  = 5'd5,
                           ST_LMUL  = 5'd6,  ST_LDLD  = 5'd7,  ST_LDIV  = 5'd8,
                           ST_LACC  = 5'd9,  ST_ELAP  = 5'd10, ST_SDIV  = 5'd11,
                           ST_SQ    = 5'd12, ST_CU    = 5'd13, ST_INR   = 5'd14,
                           ST_PM    = 5'd15, ST_PS    = 5'd16, ST_AXM   = 5'd17,
                           ST_AXS   = 5'd18, ST_OUT   = 5'd19;

    // storage
    t_axis         mem_goal [GOAL_DEPTH];
    logic [15:0]   mem_spd  [MAX_SEGS];
    t_axis         r_rdata;
    logic [15:0]   r_sp;

    logic [4:0]           r_state;
    logic [CNT_BITS-1:0]  r_cnt_cfg;
    logic [SEG_BITS-1:0]  r_seg;
    logic                 r_ready;
    logic [2:0]           r_a;

    // captured beat
    logic [SEG_BITS-1:0]  r_slot;
    t_axis                r_in_goal [AXES];
    logic [15:0]          r_in_speed;
    logic [31:0]          r_now;

    // latched segment
    t_axis                r_start [AXES];
    t_delta               r_delta [AXES];
    logic [DUR_BITS-1:0]  r_dur, r_best;
    logic [31:0]          r_start_ms;
    t_axis                r_goal;

    // math
    logic signed [2*MUL_BITS-1:0] r_prod;
    logic signed [MUL_BITS-1:0]   mul_a, mul_b;
    logic [NUM_BITS-1:0]  r_num;
    logic [DEN_BITS:0]    r_rem;
    logic [DEN_BITS-1:0]  r_den;
    logic [DUR_BITS-1:0]  r_quo;
    logic [5:0]           r_dcnt;
    logic [DUR_BITS-1:0]  r_s2, r_s3;
    logic [24:0]          r_inner;
    logic [21:0]          r_p;
    t_axis                r_res [AXES];

    // output register
    logic                      r_ovalid;
    logic [OUT_DATA_BITS-1:0]  r_odata;
    logic                      r_olast;

    // effective segment count: 0 acts as 1, clamp to table size
    logic [CNT_BITS-1:0] cnt_eff;
    always_comb begin
        cnt_eff = r_cnt_cfg;
        if (r_cnt_cfg == '0) cnt_eff = CNT_BITS'(1);
        if (r_cnt_cfg > CNT_BITS'(MAX_SEGS)) cnt_eff = CNT_BITS'(MAX_SEGS);
    end

    // goal memory read and write addresses
    logic [GADDR_BITS-1:0] seg6, prv6, rd_addr, wr_addr;
    assign seg6 = (GADDR_BITS'(r_seg) << 2) + (GADDR_BITS'(r_seg) << 1);
    assign prv6 = (r_seg == '0) ? '0 : seg6 - GADDR_BITS'(AXES);
    assign rd_addr = (r_state == ST_LRDP) ? prv6 + GADDR_BITS'(r_a)
                                          : seg6 + GADDR_BITS'(r_a);
    assign wr_addr = (GADDR_BITS'(r_slot) << 2) + (GADDR_BITS'(r_slot) << 1)
                     + GADDR_BITS'(r_a);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD) begin
            mem_goal[wr_addr] <= r_in_goal[r_a];
            if (r_a == '0) mem_spd[r_slot] <= r_in_speed;
        end
        r_rdata <= mem_goal[rd_addr];
        r_sp    <= mem_spd[r_seg];
    end

    // derived values
    logic [15:0]          sp_eff;
    logic [16:0]          mag;
    logic [27:0]          dur_num;
    logic [31:0]          el_diff;
    logic [DUR_BITS-1:0]  el;
    logic signed [26:0]   inner_w;
    logic [DEN_BITS:0]    dtrial;
    logic                 dfit;
    logic signed [31:0]   pround;
    logic signed [32:0]   vsum;
    t_axis                vsat;
    logic [31:0]          end_diff;
    logic                 seg_end;
    t_delta               d_new;

    assign sp_eff  = (r_sp == '0) ? 16'd1 : r_sp;
    assign mag     = r_delta[r_a][AXIS_BITS] ? 17'(-r_delta[r_a]) : 17'(r_delta[r_a]);
    assign dur_num = 28'(r_prod) + (28'(sp_eff) << 6);
    assign d_new   = t_delta'(r_goal) - ((r_seg == '0) ? t_delta'(0) : t_delta'(r_rdata));

    always_comb begin
        el_diff = r_now - r_start_ms;
        if (el_diff[31]) el = '0;
        else if (el_diff > 32'(r_dur)) el = r_dur;
        else el = DUR_BITS'(el_diff);
    end

    assign inner_w = (27'sd10 <<< QF)
                   - ((27'(r_quo) <<< 4) - 27'(r_quo))
                   + ((27'(r_s2) <<< 2) + (27'(r_s2) <<< 1));

    assign dtrial = {r_rem[DEN_BITS-1:0], r_num[NUM_BITS-1]};
    assign dfit   = dtrial >= {1'b0, r_den};

    assign pround = 32'((r_prod + (52'sd1 <<< (QF - 1))) >>> QF);
    assign vsum   = 33'(r_start[r_a]) + 33'(pround);
    always_comb begin
        if (vsum > 33'sd32767) vsat = t_axis'(16'h7fff);
        else if (vsum < -33'sd32768) vsat = t_axis'(16'h8000);
        else vsat = t_axis'(vsum);
    end

    assign end_diff = (r_now + END_MARGIN) - (r_start_ms + 32'(r_dur));
    assign seg_end  = (end_diff != '0) && !end_diff[31];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_LMUL: begin mul_a = MUL_BITS'(mag);   mul_b = MUL_BITS'(DUR_SCALE); end
            ST_SQ:   begin mul_a = MUL_BITS'(r_quo); mul_b = MUL_BITS'(r_quo); end
            ST_CU:   begin
                mul_a = MUL_BITS'(r_prod[2*QF:QF]);
                mul_b = MUL_BITS'(r_quo);
            end
            ST_PM:   begin mul_a = MUL_BITS'(r_s3);  mul_b = MUL_BITS'(r_inner); end
            ST_AXM:  begin
                mul_a = MUL_BITS'(r_delta[r_a]);
                mul_b = MUL_BITS'(r_p);
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt_cfg  <= SEG_COUNT_RESET;
            r_seg      <= '0;
            r_ready    <= 1'b0;
            r_a        <= '0;
            r_dur      <= '0;
            r_start_ms <= '0;
            r_ovalid   <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_start[i] <= '0;
                r_delta[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_cnt_cfg <= i_cfg_wdata;
            // ST_OUT reloads the output register itself
            if (r_ovalid && i_m_tready && (r_state != ST_OUT)) r_ovalid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_slot     <= i_s_tdata[3:0];
                        for (int i = 0; i < AXES; i++)
                            r_in_goal[i] <= t_axis'(i_s_tdata[4 + 16*i +: 16]);
                        r_in_speed <= i_s_tdata[115:100];
                        r_now      <= i_s_tdata[147:116];
                        r_a        <= '0;
                        r_state    <= (i_s_tuser == OP_TICK) ? ST_TICK : ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_a <= r_a + 3'd1;
                    if (r_a == 3'(AXES - 1)) r_state <= ST_IDLE;
                end
                ST_TICK: begin
                    if ({1'b0, r_seg} >= cnt_eff) r_seg <= SEG_BITS'(cnt_eff - 5'd1);
                    r_best  <= '0;
                    r_a     <= '0;
                    r_state <= r_ready ? ST_ELAP : ST_LRDG;
                end
                ST_LRDG: r_state <= ST_LRDP;
                ST_LRDP: begin
                    r_goal  <= r_rdata;
                    r_state <= ST_LDLT;
                end
                ST_LDLT: begin
                    r_start[r_a] <= (r_seg == '0) ? t_axis'(0) : r_rdata;
                    r_delta[r_a] <= d_new;
                    r_state      <= ST_LMUL;
                end
                ST_LMUL: r_state <= ST_LDLD;
                ST_LDLD: begin
                    r_num   <= {dur_num, 13'b0};
                    r_den   <= DEN_BITS'(sp_eff) << 7;
                    r_rem   <= '0;
                    r_dcnt  <= 6'd28;
                    r_state <= ST_LDIV;
                end
                ST_LDIV, ST_SDIV: begin
                    r_rem  <= dfit ? dtrial - {1'b0, r_den} : dtrial;
                    r_quo  <= {r_quo[DUR_BITS-2:0], dfit};
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd1)
                        r_state <= (r_state == ST_LDIV) ? ST_LACC : ST_SQ;
                end
                ST_LACC: begin
                    if (r_a == 3'(AXES - 1)) begin
                        r_dur      <= (r_quo > r_best) ? r_quo : r_best;
                        r_start_ms <= r_now;
                        r_ready    <= 1'b1;
                        r_state    <= ST_ELAP;
                    end else begin
                        if (r_quo > r_best) r_best <= r_quo;
                        r_a     <= r_a + 3'd1;
                        r_state <= ST_LRDG;
                    end
                end
                ST_ELAP: begin
                    r_a <= '0;
                    if (r_dur == '0) begin
                        r_p     <= 22'd1 << QF;
                        r_state <= ST_AXM;
                    end else begin
                        r_num   <= {el, {QF{1'b0}}};
                        r_den   <= DEN_BITS'(r_dur);
                        r_rem   <= '0;
                        r_dcnt  <= 6'(NUM_BITS);
                        r_state <= ST_SDIV;
                    end
                end
                ST_SQ: r_state <= ST_CU;         // s*s
                ST_CU: begin                     // s2*s
                    r_s2    <= r_prod[2*QF:QF];
                    r_state <= ST_INR;
                end
                ST_INR: begin
                    r_s3    <= r_prod[2*QF:QF];
                    r_inner <= inner_w[26] ? '0 : 25'(inner_w);
                    r_state <= ST_PM;
                end
                ST_PM: r_state <= ST_PS;
                ST_PS: begin
                    r_p     <= r_prod[QF+21:QF];
                    r_state <= ST_AXM;
                end
                ST_AXM: r_state <= ST_AXS;
                ST_AXS: begin
                    r_res[r_a] <= vsat;
                    r_a        <= r_a + 3'd1;
                    r_state    <= (r_a == 3'(AXES - 1)) ? ST_OUT : ST_AXM;
                end
                ST_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {4'b0, r_seg, r_res[5], r_res[4], r_res[3],
                                     r_res[2], r_res[1], r_res[0]};
                        r_olast  <= seg_end && ({1'b0, r_seg} + 5'd1 >= cnt_eff);
                        if (seg_end) begin
                            r_ready <= 1'b0;
                            r_seg   <= ({1'b0, r_seg} + 5'd1 >= cnt_eff) ? '0
                                                                        : r_seg + 4'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    // progress division only runs on a nonzero duration
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SDIV) |-> (r_dur != '0))
        else $error("progress division with zero duration");

    // the followed segment stays inside the configured sequence
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> ({1'b0, r_seg} < cnt_eff))
        else $error("segment index beyond sequence length");

endmodule

>>> dv/quintic_waypoint_trajectory_test.sv
module quintic_waypoint_trajectory_test;
    import qwt_pkg::*;

    // one input beat, unpacked
    typedef struct {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] goal [AXES];
        logic [15:0] speed;
        logic [31:0] now;
    } t_wp_beat;

    // one expected pose beat
    typedef struct {
        logic [15:0] axis [AXES];
        logic [3:0]  seg;
        logic        done;
    } t_pose;

    localparam int  DRAIN_CYCLES = 400;
    localparam longint CYCLE_LIMIT = 1_500_000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CNT_BITS-1:0]      i_cfg_wdata;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;
    logic                     o_m_tlast;

    quintic_waypoint_trajectory dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Trajectory predictor: private copy of the table and segment state
    // ------------------------------------------------------------------
    logic signed [15:0] goal_tab [MAX_SEGS][AXES];
    logic [15:0]        speed_tab [MAX_SEGS];
    int unsigned        seg_count;
    int unsigned        cur_seg;
    bit                 seg_latched;
    longint             seg_start [AXES];
    longint             seg_delta [AXES];
    longint unsigned    seg_dur;
    logic [31:0]        seg_t0;

    t_wp_beat beat_q [$];    // beats waiting for the driver
    t_pose    pose_q [$];    // poses the block still owes us
    int       errors;
    bit       drain_only;    // stimulus of this phase fully queued

    // start pose, deltas and duration of the current segment
    function automatic void latch_seg(input logic [31:0] now);
        longint unsigned sp, mag, dur, best;
        longint st, d;
        best = 0;
        sp = speed_tab[cur_seg];
        if (sp == 0) sp = 1;
        for (int a = 0; a < AXES; a++) begin
            st = (cur_seg == 0) ? 0 : longint'(goal_tab[cur_seg-1][a]);
            d = longint'(goal_tab[cur_seg][a]) - st;
            mag = (d < 0) ? -d : d;
            dur = (mag * 2000 + sp * 64) / (sp * 128);
            seg_start[a] = st;
            seg_delta[a] = d;
            if (dur > best) best = dur;
        end
        seg_dur = best;
        seg_t0 = now;
        seg_latched = 1'b1;
    endfunction

    function automatic void apply_beat(input t_wp_beat b);
        t_pose pe;
        int unsigned cnt;
        longint unsigned s, s2, s3, el;
        longint inner, p, v;
        logic [31:0] diff, end_t;
        if (b.op == OP_LOAD) begin
            for (int a = 0; a < AXES; a++) goal_tab[b.slot][a] = b.goal[a];
            speed_tab[b.slot] = b.speed;
            return;
        end
        cnt = (seg_count == 0) ? 1 : (seg_count > MAX_SEGS ? MAX_SEGS : seg_count);
        if (cur_seg >= cnt) cur_seg = cnt - 1;
        if (!seg_latched) latch_seg(b.now);
        if (seg_dur == 0) begin
            p = longint'(1) << QF;
        end else begin
            diff = b.now - seg_t0;
            el = diff[31] ? 0 : diff;
            if (el > seg_dur) el = seg_dur;
            s = (el << QF) / seg_dur;
            s2 = (s * s) >> QF;
            s3 = (s2 * s) >> QF;
            inner = (longint'(10) << QF) - 15 * longint'(s) + 6 * longint'(s2);
            if (inner < 0) inner = 0;
            p = longint'((s3 * longint'(inner)) >> QF);
        end
        for (int a = 0; a < AXES; a++) begin
            // arithmetic shift gives the floor, hence round half up
            v = seg_start[a] + ((seg_delta[a] * p + (longint'(1) << (QF - 1))) >>> QF);
            if (v < -32768) v = -32768;
            if (v > 32767) v = 32767;
            pe.axis[a] = v[15:0];
        end
        pe.seg = cur_seg[3:0];
        pe.done = 1'b0;
        end_t = seg_t0 + seg_dur[31:0];
        diff = (b.now + END_MARGIN) - end_t;
        if (diff != 0 && !diff[31]) begin
            seg_latched = 1'b0;
            if (cur_seg + 1 >= cnt) begin
                cur_seg = 0;
                pe.done = 1'b1;
            end else begin
                cur_seg++;
            end
        end
        pose_q.push_back(pe);
    endfunction

    // ------------------------------------------------------------------
    // Driver: slave side, random gap before each beat
    // ------------------------------------------------------------------
    int  s_gap;
    bit  s_burst;     // stretch with no idling
    t_wp_beat s_cur;

    always @(posedge i_clk) begin
        bit take;
        logic [IN_DATA_BITS-1:0] d;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            s_gap = 0;
        end else begin
            take = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                apply_beat(s_cur);
                s_gap = s_burst ? 0 : $urandom_range(0, 17);
                take = 1'b1;
            end
            if (!i_s_tvalid || take) begin
                if (s_gap > 0) begin
                    s_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (beat_q.size() > 0) begin
                    s_cur = beat_q.pop_front();
                    d = '0;
                    d[3:0] = s_cur.slot;
                    for (int a = 0; a < AXES; a++) d[4 + 16*a +: 16] = s_cur.goal[a];
                    d[115:100] = s_cur.speed;
                    d[147:116] = s_cur.now;
                    i_s_tdata  <= d;
                    i_s_tuser  <= s_cur.op;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: master side, random stall per beat, field-by-field check
    // ------------------------------------------------------------------
    int m_stall;
    bit m_burst;

    always @(posedge i_clk) begin
        t_pose pe;
        logic [15:0] got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            m_stall = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (pose_q.size() == 0) begin
                    $display("%0t: unexpected pose beat %h last %b", $time, o_m_tdata,
                             o_m_tlast);
                    errors++;
                end else begin
                    pe = pose_q.pop_front();
                    for (int a = 0; a < AXES; a++) begin
                        got = o_m_tdata[16*a +: 16];
                        if (got !== pe.axis[a]) begin
                            $display("%0t: axis %0d expected %h actual %h", $time, a,
                                     pe.axis[a], got);
                            errors++;
                        end
                    end
                    if (o_m_tdata[99:96] !== pe.seg) begin
                        $display("%0t: segment expected %0d actual %0d", $time, pe.seg,
                                 o_m_tdata[99:96]);
                        errors++;
                    end
                    if (o_m_tlast !== pe.done) begin
                        $display("%0t: sequence done expected %b actual %b", $time,
                                 pe.done, o_m_tlast);
                        errors++;
                    end
                end
                m_stall = m_burst ? 0 : $urandom_range(0, 17);
            end
            if (m_stall > 0) begin
                m_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // run-away guard
    longint cycles;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("quintic_waypoint_trajectory test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [31:0] t_now;

    function automatic t_wp_beat rand_beat(input logic op);
        t_wp_beat b;
        b.op = op;
        b.slot = 4'($urandom_range(0, 15));
        for (int a = 0; a < AXES; a++) b.goal[a] = 16'($urandom);
        b.speed = 16'($urandom);
        b.now = $urandom;
        return b;
    endfunction

    // load with goals of random scale so durations spread from 0 to long
    task automatic push_load(input int slot);
        t_wp_beat b;
        int sc;
        b = rand_beat(OP_LOAD);
        b.slot = 4'(slot);
        sc = $urandom_range(0, 15);
        for (int a = 0; a < AXES; a++)
            b.goal[a] = 16'(int'($urandom_range(0, (2 << sc) - 1)) - (1 << sc));
        if ($urandom_range(0, 9) == 0) b.goal[$urandom_range(0, 5)] = 16'($urandom);
        b.speed = 16'(($urandom_range(1, 255)) << $urandom_range(0, 8));
        if ($urandom_range(0, 30) == 0) b.speed = 0;
        beat_q.push_back(b);
    endtask

    task automatic push_tick(input logic [31:0] now);
        t_wp_beat b;
        b = rand_beat(OP_TICK);
        b.now = now;
        beat_q.push_back(b);
    endtask

    task automatic push_load_fixed(input int slot, input logic [15:0] g,
                                   input logic [15:0] sp);
        t_wp_beat b;
        b = rand_beat(OP_LOAD);
        b.slot = 4'(slot);
        for (int a = 0; a < AXES; a++) b.goal[a] = g;
        b.speed = sp;
        beat_q.push_back(b);
    endtask

    // wait until everything sent has been answered and the block is quiet
    task automatic settle();
        while (beat_q.size() > 0 || i_s_tvalid || pose_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(input int unsigned c);
        i_cfg_wdata <= c[CNT_BITS-1:0];
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        seg_count = c;
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial begin
        int unsigned counts [6];
        int r;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = OP_LOAD;
        i_m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        s_burst = 1'b0;
        m_burst = 1'b0;
        seg_count = SEG_COUNT_RESET;
        cur_seg = 0;
        seg_latched = 1'b0;
        seg_dur = 0;
        seg_t0 = 0;
        for (int a = 0; a < AXES; a++) begin
            seg_start[a] = 0;
            seg_delta[a] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: full-scale goals, zero speed, zero-length segment,
        // time before start, wrap of the ms counter, every slot written
        set_count(16);
        push_load_fixed(0, 16'h7fff, 16'hffff);
        push_load_fixed(1, 16'h8000, 16'h0000);
        push_load_fixed(2, 16'h8000, 16'd5);
        for (int i = 3; i < MAX_SEGS; i++) push_load(i);
        push_tick(32'd0);
        push_tick(32'd3);
        push_tick(32'd100);
        push_tick(32'd50);
        push_tick(32'd40);
        push_tick(32'd512050);
        push_tick(32'hffff_ffff);
        push_tick(32'd2_000_000);
        push_tick(32'd2_000_001);
        settle();

        // random phases, extremes of the count among them
        counts[0] = 1;
        counts[1] = 16;
        counts[2] = 2;
        counts[3] = $urandom_range(3, 15);
        counts[4] = 16;
        counts[5] = $urandom_range(2, 15);
        t_now = 32'd3_000_000;
        for (int ph = 0; ph < 6; ph++) begin
            set_count(counts[ph]);
            s_burst = (ph == 2);
            m_burst = (ph == 4);
            if (ph == 4) t_now = 32'hffff_f000 + $urandom_range(0, 4095);
            for (int n = 0; n < 85; n++) begin
                r = $urandom_range(0, 99);
                if (ph == 3 && n == 40) begin
                    s_burst = !s_burst;
                    m_burst = !m_burst;
                end
                if (r < 18) begin
                    push_load($urandom_range(0, 15));
                end else begin
                    if (r < 22)
                        t_now = t_now + $urandom_range(0, 1 << 20);
                    else if (r < 25)
                        t_now = t_now - $urandom_range(0, 300);
                    else if (r < 27)
                        t_now = $urandom;
                    else
                        t_now = t_now + $urandom_range(0, 400);
                    push_tick(t_now);
                end
            end
            settle();
        end

        if (errors == 0) begin
            $display("quintic_waypoint_trajectory test passed");
        end else begin
            $display("quintic_waypoint_trajectory test failed");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/qwt_pkg.sv
hdl/quintic_waypoint_trajectory.sv
dv/quintic_waypoint_trajectory_test.sv
